/* hdl/fracr_pkg.sv */
package fracr_pkg;

  localparam int unsigned InWidthDef  = 16;
  localparam int unsigned AccWidthDef = 31;

  // s_axis_tuser bit positions
  localparam int unsigned UserStartBit  = 0;
  localparam int unsigned UserReduceBit = 1;
  localparam int unsigned InUserWidth   = 2;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic chk;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic gcd_done;
  } sts_t;

endpackage

/* hdl/fraction_accumulate_reduce_unit.sv */
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: numerator, denominator; tuser: start, reduce
// m_axis    out  m_axis_tvalid/tready    tdata: sums, reducible, reduced terms; tuser: status
//
// One item at a time: an accept step, IN_WIDTH multiply steps, a check, a binary gcd
// loop, ACC_WIDTH divide steps and a commit; on overflow the gcd and divide steps are
// skipped. Only the gcd loop varies in length, with the operands.
// A new word is taken while the previous result waits on m_axis; the commit then
// stalls until the output register is free.
// Reset sets the accumulator to 0/1 and empties the output register.
module fraction_accumulate_reduce_unit #(
  parameter int unsigned IN_WIDTH  = fracr_pkg::InWidthDef,
  parameter int unsigned ACC_WIDTH = fracr_pkg::AccWidthDef,
  localparam int unsigned InDataW  = ((2 * IN_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((4 * ACC_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // addend_numerator, addend_denominator, zero pad
  input  logic [InDataW-1:0]                s_axis_tdata,
  // start_req, reduce_after
  input  logic [fracr_pkg::InUserWidth-1:0] s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sum_numerator, sum_denominator, reducible, reduced_numerator,
  // reduced_denominator, zero pad
  output logic [OutDataW-1:0]               m_axis_tdata,
  // status
  output logic                              m_axis_tuser
);

  fracr_pkg::cmd_t cmd;
  fracr_pkg::sts_t sts;

  fracr_ctrl #(
    .IN_WIDTH (IN_WIDTH),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fracr_dp #(
    .IN_WIDTH (IN_WIDTH),
    .ACC_WIDTH(ACC_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_data_i (s_axis_tdata),
    .in_user_i (s_axis_tuser),
    .out_data_o(m_axis_tdata),
    .out_user_o(m_axis_tuser)
  );

endmodule

/* hdl/fracr_ctrl.sv */
module fracr_ctrl #(
  parameter int unsigned IN_WIDTH  = fracr_pkg::InWidthDef,
  parameter int unsigned ACC_WIDTH = fracr_pkg::AccWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  fracr_pkg::sts_t  sts_i,
  output fracr_pkg::cmd_t  cmd_o
);

  localparam int unsigned CntMax = (IN_WIDTH > ACC_WIDTH) ? IN_WIDTH : ACC_WIDTH;
  localparam int unsigned CW     = $clog2(CntMax);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StGcd  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_vld_q, out_vld_d;
  logic          out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;
  assign out_free    = !out_vld_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    out_vld_d = out_vld_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == CW'(IN_WIDTH - 1)) begin
          state_d = StChk;
        end
      end
      StChk: begin
        cmd_o.chk = 1'b1;
        state_d   = StGcd;
      end
      StGcd: begin
        if (sts_i.ovf) begin
          state_d = StFin;
        end else if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = StDiv;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == CW'(ACC_WIDTH - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

/* hdl/fracr_dp.sv */
module fracr_dp #(
  parameter int unsigned IN_WIDTH  = fracr_pkg::InWidthDef,
  parameter int unsigned ACC_WIDTH = fracr_pkg::AccWidthDef,
  localparam int unsigned InDataW  = ((2 * IN_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((4 * ACC_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fracr_pkg::cmd_t                  cmd_i,
  output fracr_pkg::sts_t                  sts_o,
  input  logic [InDataW-1:0]               in_data_i,
  input  logic [fracr_pkg::InUserWidth-1:0] in_user_i,
  output logic [OutDataW-1:0]              out_data_o,
  output logic                             out_user_o
);

  localparam int unsigned IW = IN_WIDTH;
  localparam int unsigned AW = ACC_WIDTH;
  localparam int unsigned PW = AW + IW;
  localparam int unsigned KW = $clog2(AW);

  // accumulator
  logic [AW-1:0] acc_num_q, acc_den_q;

  // captured item
  logic [IW-1:0] c_q, d_q;
  logic          load_q, red_q;

  // shift-add multipliers
  logic [IW-1:0] mc_q, md_q;
  logic [PW-1:0] pa_q, pb_q;
  logic [PW-1:0] ad_q, cb_q, bd_q;

  // sum and gcd
  logic [AW-1:0] num_q, den_q;
  logic          ovf_q;
  logic [AW-1:0] gx_q, gy_q;
  logic [KW-1:0] gk_q;

  // restoring dividers
  logic [AW-1:0] g_q;
  logic [AW-1:0] qn_q, qd_q, rn_q, rd_q;

  // output register
  logic [OutDataW-1:0] out_data_q;
  logic                out_user_q;

  logic [PW-1:0] c_ext, d_ext;
  logic [AW:0]   sum_w;
  logic          ovf_w;
  logic [AW-1:0] num_w, den_w;
  logic [AW-1:0] gxy, gshift, gval;
  logic [AW:0]   tn, td, tn_sub, td_sub;
  logic          bn, bd;
  logic          reducible;

  assign c_ext = PW'(in_data_i[IW-1:0]);
  assign d_ext = PW'(in_data_i[2*IW-1:IW]);

  always_comb begin
    if (load_q) begin
      num_w = AW'(PW'(c_q));
      den_w = AW'(PW'(d_q));
      ovf_w = (|(PW'(c_q) >> AW)) || (|(PW'(d_q) >> AW));
      sum_w = '0;
    end else begin
      sum_w = {1'b0, ad_q[AW-1:0]} + {1'b0, cb_q[AW-1:0]};
      num_w = sum_w[AW-1:0];
      den_w = bd_q[AW-1:0];
      ovf_w = (|ad_q[PW-1:AW]) || (|cb_q[PW-1:AW]) || (|bd_q[PW-1:AW]) || sum_w[AW];
    end
  end

  assign gxy    = gx_q | gy_q;
  assign gshift = gxy << gk_q;
  assign gval   = (gshift == '0) ? AW'(1) : gshift;

  assign tn     = {rn_q, qn_q[AW-1]};
  assign td     = {rd_q, qd_q[AW-1]};
  assign tn_sub = tn - {1'b0, g_q};
  assign td_sub = td - {1'b0, g_q};
  assign bn     = (tn >= {1'b0, g_q});
  assign bd     = (td >= {1'b0, g_q});

  assign reducible = (g_q > AW'(1));

  assign sts_o.ovf      = ovf_q;
  assign sts_o.gcd_done = (gx_q == '0) || (gy_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_num_q <= '0;
      acc_den_q <= AW'(1);
    end else if (cmd_i.commit && !ovf_q) begin
      if (red_q) begin
        acc_num_q <= qn_q;
        acc_den_q <= qd_q;
      end else begin
        acc_num_q <= num_q;
        acc_den_q <= den_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q    <= c_ext[IW-1:0];
      d_q    <= d_ext[IW-1:0];
      load_q <= in_user_i[fracr_pkg::UserStartBit];
      red_q  <= in_user_i[fracr_pkg::UserReduceBit];
      mc_q   <= c_ext[IW-1:0];
      md_q   <= d_ext[IW-1:0];
      pa_q   <= PW'(acc_num_q);
      pb_q   <= PW'(acc_den_q);
      ad_q   <= '0;
      cb_q   <= '0;
      bd_q   <= '0;
    end else if (cmd_i.mul_step) begin
      if (md_q[0]) begin
        ad_q <= ad_q + pa_q;
        bd_q <= bd_q + pb_q;
      end
      if (mc_q[0]) begin
        cb_q <= cb_q + pb_q;
      end
      pa_q <= pa_q << 1;
      pb_q <= pb_q << 1;
      mc_q <= mc_q >> 1;
      md_q <= md_q >> 1;
    end

    if (cmd_i.chk) begin
      num_q <= num_w;
      den_q <= den_w;
      ovf_q <= ovf_w;
      gx_q  <= num_w;
      gy_q  <= den_w;
      gk_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1;
        gy_q <= gy_q >> 1;
        gk_q <= gk_q + KW'(1);
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else if (gx_q >= gy_q) begin
        gx_q <= gx_q - gy_q;
      end else begin
        gy_q <= gy_q - gx_q;
      end
    end

    if (cmd_i.div_init) begin
      g_q  <= gval;
      qn_q <= num_q;
      qd_q <= den_q;
      rn_q <= '0;
      rd_q <= '0;
    end else if (cmd_i.div_step) begin
      rn_q <= bn ? tn_sub[AW-1:0] : tn[AW-1:0];
      rd_q <= bd ? td_sub[AW-1:0] : td[AW-1:0];
      qn_q <= {qn_q[AW-2:0], bn};
      qd_q <= {qd_q[AW-2:0], bd};
    end

    if (cmd_i.commit) begin
      if (ovf_q) begin
        out_data_q <= '0;
        out_user_q <= 1'b1;
      end else begin
        out_data_q <= OutDataW'({qd_q, qn_q, reducible, den_q, num_q});
        out_user_q <= 1'b0;
      end
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned InW      = fracr_pkg::InWidthDef;
  localparam int unsigned AccW     = fracr_pkg::AccWidthDef;
  localparam int unsigned InDataW  = ((2 * InW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((4 * AccW + 1 + 7) / 8) * 8;
  localparam longint unsigned AccMax = (64'd1 << AccW) - 64'd1;
  localparam int unsigned NumWords   = 800;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 1500;

  typedef struct packed {
    logic           start;
    logic           reduce;
    logic [InW-1:0] num;
    logic [InW-1:0] den;
  } frac_word_t;

  // m_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [OutDataW-4*AccW-2:0] pad;
    logic [AccW-1:0]            red_den;
    logic [AccW-1:0]            red_num;
    logic                       reducible;
    logic [AccW-1:0]            sum_den;
    logic [AccW-1:0]            sum_num;
  } sum_word_t;

  typedef struct packed {
    logic      ovf;
    sum_word_t word;
  } sum_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [InDataW-1:0]                s_axis_tdata = '0;
  logic [fracr_pkg::InUserWidth-1:0] s_axis_tuser = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [OutDataW-1:0]               m_axis_tdata;
  logic                              m_axis_tuser;

  fraction_accumulate_reduce_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  frac_word_t      word_queue[$];
  sum_result_t     sums_due[$];
  frac_word_t      word_on_bus;
  longint unsigned acc_num = 64'd0;
  longint unsigned acc_den = 64'd1;
  int unsigned     total_words = 0;
  int unsigned     words_taken = 0;
  int unsigned     results_seen = 0;
  int unsigned     errors = 0;
  int unsigned     ovf_count = 0;
  int unsigned     reducible_count = 0;
  int unsigned     hold_left = 0;
  bit              held = 1'b0;
  int unsigned     stall_cycles = 0;

  function automatic frac_word_t make_word(bit start, int unsigned num, int unsigned den,
                                           bit reduce);
    frac_word_t w;
    w.start  = start;
    w.reduce = reduce;
    w.num    = num[InW-1:0];
    w.den    = den[InW-1:0];
    return w;
  endfunction

  function automatic int unsigned rand_term();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 60) return $urandom_range(1, 15);
    if (r < 85) return $urandom_range(1, 255);
    return $urandom_range(0, (1 << InW) - 1);
  endfunction

  // load or cross-multiply add, then gcd reduce; updates the accumulator unless it overflows
  function automatic sum_result_t add_fraction(frac_word_t w);
    sum_result_t     e;
    longint unsigned c, d, num, den, ad, cb, x, y, t, g;
    bit              ok;
    e = '0;
    c = w.num;
    d = w.den;
    if (w.start) begin
      num = c;
      den = d;
      ok  = (c <= AccMax) && (d <= AccMax);
    end else begin
      ad  = acc_num * d;
      cb  = c * acc_den;
      den = acc_den * d;
      ok  = (ad <= AccMax) && (cb <= AccMax) && (den <= AccMax) && (ad + cb <= AccMax);
      num = ad + cb;
    end
    if (!ok) begin
      e.ovf = 1'b1;
      ovf_count++;
      return e;
    end
    x = num;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = (x == 0) ? 64'd1 : x;
    e.word.sum_num   = num[AccW-1:0];
    e.word.sum_den   = den[AccW-1:0];
    e.word.reducible = (g > 1);
    e.word.red_num   = AccW'(num / g);
    e.word.red_den   = AccW'(den / g);
    if (g > 1) reducible_count++;
    if (w.reduce) begin
      acc_num = num / g;
      acc_den = den / g;
    end else begin
      acc_num = num;
      acc_den = den;
    end
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic [fracr_pkg::InUserWidth-1:0] user;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sums_due.push_back(add_fraction(word_on_bus));
        words_taken <= words_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_queue.size() > 0 &&
            ((words_taken >= 400 && words_taken < 550) || $urandom_range(0, 99) >= 13)) begin
          word_on_bus = word_queue.pop_front();
          user = '0;
          user[fracr_pkg::UserStartBit]  = word_on_bus.start;
          user[fracr_pkg::UserReduceBit] = word_on_bus.reduce;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= InDataW'({word_on_bus.den, word_on_bus.num});
          s_axis_tuser  <= user;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink ready: random idling, a stretch of steady readiness, and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!held && results_seen >= 150) begin
      held          <= 1'b1;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (results_seen >= 380 && results_seen < 530) ||
                       ($urandom_range(0, 99) >= 13);
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    sum_word_t   got;
    sum_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = sum_word_t'(m_axis_tdata);
      results_seen <= results_seen + 1;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h / %b",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = sums_due.pop_front();
        check_field("sum_numerator", want.word.sum_num, got.sum_num);
        check_field("sum_denominator", want.word.sum_den, got.sum_den);
        check_field("reducible", want.word.reducible, got.reducible);
        check_field("reduced_numerator", want.word.red_num, got.red_num);
        check_field("reduced_denominator", want.word.red_den, got.red_den);
        check_field("status", want.ovf, m_axis_tuser);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: timeout, %0d cycles without a handshake", $time, stall_cycles);
        $display("tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned adds;
    // add from reset state, then an add with reduction
    word_queue.push_back(make_word(0, 3, 4, 0));
    word_queue.push_back(make_word(0, 1, 4, 1));
    // largest terms; denominator product overflow
    word_queue.push_back(make_word(1, 65535, 65535, 0));
    word_queue.push_back(make_word(0, 65535, 65535, 1));
    // products fit, their sum does not
    word_queue.push_back(make_word(1, 46000, 46000, 0));
    word_queue.push_back(make_word(0, 46000, 46000, 1));
    // zero numerator
    word_queue.push_back(make_word(1, 0, 5, 1));
    word_queue.push_back(make_word(0, 2, 3, 0));
    // zero denominator
    word_queue.push_back(make_word(1, 7, 0, 1));
    word_queue.push_back(make_word(0, 5, 9, 0));
    // both terms zero
    word_queue.push_back(make_word(1, 0, 0, 1));
    word_queue.push_back(make_word(0, 0, 0, 0));
    // cross product overflow
    word_queue.push_back(make_word(1, 1, 65535, 0));
    word_queue.push_back(make_word(0, 65535, 1, 1));
    word_queue.push_back(make_word(1, 12, 18, 1));
    word_queue.push_back(make_word(0, 5, 6, 1));
    word_queue.push_back(make_word(0, 1, 2, 0));
    word_queue.push_back(make_word(0, 1, 2, 1));
    while (word_queue.size() < NumWords) begin
      if ($urandom_range(0, 9) == 0) begin
        word_queue.push_back(make_word($urandom_range(0, 1), $urandom_range(0, 65535),
                                       $urandom_range(0, 65535), $urandom_range(0, 1)));
      end else begin
        word_queue.push_back(make_word(1, rand_term(), rand_term(), $urandom_range(0, 1)));
        adds = $urandom_range(0, 7);
        repeat (adds) begin
          word_queue.push_back(make_word(0, rand_term(), rand_term(),
                                         $urandom_range(0, 3) != 0));
        end
      end
    end
    total_words = word_queue.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i); while (words_taken != total_words || sums_due.size() != 0);
    repeat (300) @(negedge clk_i);

    $display("summary: %0d words in, %0d results checked", words_taken, results_seen);
    $display("summary: %0d overflows, %0d reducible sums, one %0d-cycle sink hold-off",
             ovf_count, reducible_count, HoldCycles);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
